### sv/gasp_pkg.sv
// Shared types, constants and helper functions for the glyph atlas shelf packer.
`timescale 1ns / 1ps
`default_nettype none

package gasp_pkg;

  // Fixed spacing between boxes and margins used by the row and start-point logic
  localparam int unsigned GapX        = 1;
  localparam int unsigned GapY        = 1;
  localparam int unsigned FitMargin   = 2;
  localparam int unsigned VBias       = 1;

  // Register reset values
  localparam logic [12:0] AtlasWReset = 13'd256;
  localparam logic [12:0] AtlasHReset = 13'd256;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CfgAtlasW     = 4'd0,
    CfgAtlasH     = 4'd1,
    CfgShadowDx   = 4'd2,
    CfgShadowDy   = 4'd3,
    CfgGrowLeft   = 4'd4,
    CfgGrowRight  = 4'd5,
    CfgGrowTop    = 4'd6,
    CfgGrowBottom = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0]       atlas_w;
    logic [12:0]       atlas_h;
    logic [4:0]        shadow_dx;
    logic [4:0]        shadow_dy;
    logic signed [7:0] grow_left;
    logic signed [7:0] grow_right;
    logic signed [7:0] grow_top;
    logic signed [7:0] grow_bottom;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [9:0] glyph_w;
    logic [9:0] glyph_h;
  } item_t;

  typedef struct packed {
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic [10:0] row_tall;
    logic [7:0]  page_count;
  } state_t;

  typedef struct packed {
    logic [11:0] start_u;
    logic [11:0] start_v;
    logic [12:0] box_w;
    logic [12:0] box_h;
    logic [7:0]  page_no;
    logic        page_closed;
    logic [12:0] closed_height;
  } result_t;

  // Saturate a non-negative 14-bit sum to 13 bits
  function automatic logic [12:0] sat13(input logic [13:0] v);
    return v[13] ? 13'h1FFF : v[12:0];
  endfunction

  // Sign-extend an 8-bit margin to the 15-bit working width
  function automatic logic signed [14:0] sext8(input logic signed [7:0] g);
    return {{7{g[7]}}, g};
  endfunction

  // Clamp a signed value into [0, hi]
  function automatic logic [12:0] clamp0(input logic signed [14:0] v,
                                         input logic [12:0] hi);
    logic signed [14:0] hi_s;
    hi_s = $signed({2'b00, hi});
    if (v < 15'sd0) begin
      return 13'd0;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[12:0];
    end
  endfunction

endpackage

`default_nettype wire

### sv/glyph_atlas_shelf_packer_top.sv
// Top level of the glyph atlas shelf packer: item registers, cursor state and result register.
//
//  channel  direction  handshake                    payload
//  in       sink       in_valid_i / in_stall_o      mode_i, glyph_w_i, glyph_h_i
//  out      source     out_valid_o / out_stall_i    start_u_o .. closed_height_o
//  cfg      sink       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the result is not stalled. An item waits in the input register,
//  where the placement logic and the cursor update run, then sits in the result register.
//  Reset clears the cursor state, the valid flags and loads the register defaults.
//  A stalled result holds the input register; the input stalls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module glyph_atlas_shelf_packer_top
  import gasp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [9:0]  glyph_w_i,
  input  wire logic [9:0]  glyph_h_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      start_u_o,
  output logic [11:0]      start_v_o,
  output logic [12:0]      box_w_o,
  output logic [12:0]      box_h_o,
  output logic [7:0]       page_no_o,
  output logic             page_closed_o,
  output logic [12:0]      closed_height_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  state_t  st_q;
  state_t  st_d;
  result_t res_d;
  result_t out_q;
  logic    out_valid_q;
  logic    mv;

  assign cfg_ready_o = 1'b1;

  gasp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  gasp_place u_place (
    .item_i (in_q),
    .st_i   (st_q),
    .cfg_i  (cfg),
    .res_o  (res_d),
    .st_o   (st_d)
  );

  // Item moves on when the result register is empty or being drained
  assign mv         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !mv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= '{mode: mode_i, glyph_w: glyph_w_i, glyph_h: glyph_h_i};
    end
  end

  // Cursor state advances with each item that is placed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (mv) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign start_u_o       = out_q.start_u;
  assign start_v_o       = out_q.start_v;
  assign box_w_o         = out_q.box_w;
  assign box_h_o         = out_q.box_h;
  assign page_no_o       = out_q.page_no;
  assign page_closed_o   = out_q.page_closed;
  assign closed_height_o = out_q.closed_height;

  // A finish item leaves the cursor state cleared
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv && in_q.mode) |=> (st_q == '0))
    else $error("state not cleared after finish item");

  // An item held in the input register is neither lost nor altered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !mv) |=> (in_valid_q && $stable(in_q)))
    else $error("held item lost or changed");

  // The input only stalls when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A result that closed no page reports no closed height
  a_closed_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.page_closed) |-> (out_q.closed_height == 13'd0))
    else $error("closed height without page close");

  // Cursor state, page count included, only moves on a placed item
  a_page_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mv |=> $stable(st_q))
    else $error("cursor state changed without an item");

endmodule

`default_nettype wire

### sv/gasp_cfg.sv
// Configuration register bank for the shelf packer.
`timescale 1ns / 1ps
`default_nettype none

module gasp_cfg
  import gasp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [3:0]  wr_index_i,
  input  wire logic [12:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{atlas_w:     AtlasWReset,
                 atlas_h:     AtlasHReset,
                 shadow_dx:   5'd0,
                 shadow_dy:   5'd0,
                 grow_left:   8'sd0,
                 grow_right:  8'sd0,
                 grow_top:    8'sd0,
                 grow_bottom: 8'sd0};
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CfgAtlasW:     cfg_q.atlas_w     <= wr_data_i;
        CfgAtlasH:     cfg_q.atlas_h     <= wr_data_i;
        CfgShadowDx:   cfg_q.shadow_dx   <= wr_data_i[4:0];
        CfgShadowDy:   cfg_q.shadow_dy   <= wr_data_i[4:0];
        CfgGrowLeft:   cfg_q.grow_left   <= $signed(wr_data_i[7:0]);
        CfgGrowRight:  cfg_q.grow_right  <= $signed(wr_data_i[7:0]);
        CfgGrowTop:    cfg_q.grow_top    <= $signed(wr_data_i[7:0]);
        CfgGrowBottom: cfg_q.grow_bottom <= $signed(wr_data_i[7:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/gasp_place.sv
// Placement logic: row wrap, page break, clamps and next cursor state for one item.
`timescale 1ns / 1ps
`default_nettype none

module gasp_place
  import gasp_pkg::*;
(
  input  item_t   item_i,
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  output result_t res_o,
  output state_t  st_o
);

  logic [10:0]        w;
  logic [10:0]        h;
  logic [13:0]        fit_sum;
  logic               wrap;
  logic [12:0]        x_a;
  logic [12:0]        y_a;
  logic [10:0]        row_a;
  logic [10:0]        row_b;
  logic               brk;
  logic [12:0]        closed_h;
  logic [12:0]        x_f;
  logic [12:0]        y_f;
  logic [10:0]        row_f;
  logic [12:0]        hi_u;
  logic [12:0]        hi_v;
  logic [12:0]        su_c;
  logic [12:0]        sv_c;
  logic [11:0]        su;
  logic [11:0]        sv;
  logic signed [14:0] du;
  logic signed [14:0] dv;
  logic signed [14:0] dw;
  logic signed [14:0] dh;
  logic [12:0]        bw;
  logic [12:0]        bh;

  // Glyph size with shadow offsets
  assign w = {1'b0, item_i.glyph_w} + {6'd0, cfg_i.shadow_dx};
  assign h = {1'b0, item_i.glyph_h} + {6'd0, cfg_i.shadow_dy};

  // Row wrap when the glyph plus right margin overruns the page width
  assign fit_sum = {3'd0, w} + {1'b0, st_i.cursor_x} + 14'(FitMargin);
  assign wrap    = fit_sum > {1'b0, cfg_i.atlas_w};
  assign x_a     = wrap ? 13'd0 : st_i.cursor_x;
  assign y_a     = wrap ? sat13({1'b0, st_i.cursor_y} + {3'd0, st_i.row_tall} + 14'(GapY))
                        : st_i.cursor_y;
  assign row_a   = wrap ? 11'd0 : st_i.row_tall;
  assign row_b   = (h > row_a) ? h : row_a;

  // Page break when the row overruns the page height
  assign brk      = ({1'b0, y_a} + {3'd0, row_b}) > {1'b0, cfg_i.atlas_h};
  assign closed_h = sat13({1'b0, y_a} + {3'd0, row_a});
  assign x_f      = brk ? 13'd0 : x_a;
  assign y_f      = brk ? 13'd0 : y_a;
  assign row_f    = brk ? h : row_b;

  // Upper bounds for the start point: page size minus one, held to 12 bits
  assign hi_u = (cfg_i.atlas_w == 13'd0) ? 13'd0 :
                (cfg_i.atlas_w > 13'd4096) ? 13'd4095 : cfg_i.atlas_w - 13'd1;
  assign hi_v = (cfg_i.atlas_h == 13'd0) ? 13'd0 :
                (cfg_i.atlas_h > 13'd4096) ? 13'd4095 : cfg_i.atlas_h - 13'd1;

  // Start point
  assign du   = $signed({2'b00, x_f}) - sext8(cfg_i.grow_left);
  assign dv   = $signed({2'b00, y_f}) + 15'(VBias) - sext8(cfg_i.grow_top);
  assign su_c = clamp0(du, hi_u);
  assign sv_c = clamp0(dv, hi_v);
  assign su   = su_c[11:0];
  assign sv   = sv_c[11:0];

  // Box size, bounded by what is left of the page past the start point
  assign dw = $signed({4'd0, w}) + sext8(cfg_i.grow_left) + sext8(cfg_i.grow_right);
  assign dh = $signed({4'd0, h}) + sext8(cfg_i.grow_top) + sext8(cfg_i.grow_bottom);
  assign bw = clamp0(dw, cfg_i.atlas_w - {1'b0, su});
  assign bh = clamp0(dh, cfg_i.atlas_h - {1'b0, sv});

  // Result and next state; a finish item closes the page and clears state
  always_comb begin
    res_o = '0;
    st_o  = '0;
    if (item_i.mode) begin
      res_o.page_no       = st_i.page_count;
      res_o.page_closed   = 1'b1;
      res_o.closed_height = sat13({1'b0, st_i.cursor_y} + {3'd0, st_i.row_tall});
    end else begin
      st_o.page_count     = brk ? st_i.page_count + 8'd1 : st_i.page_count;
      res_o.start_u       = su;
      res_o.start_v       = sv;
      res_o.box_w         = bw;
      res_o.box_h         = bh;
      res_o.page_no       = st_o.page_count;
      res_o.page_closed   = brk;
      res_o.closed_height = brk ? closed_h : 13'd0;
      st_o.cursor_x       = sat13({1'b0, x_f} + {3'd0, w} + 14'(GapX));
      st_o.cursor_y       = y_f;
      st_o.row_tall       = row_f;
    end
  end

endmodule

`default_nettype wire
